FILE: design/ncs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types and constants for the nearest palette color search block.
// ----------------------------------------------------------------------------
package ncs_pkg;

  localparam int NCS_PALETTE_ENTRIES = 256;
  localparam int NCS_IDX_W           = 8;   // nearest_index / entry_index width
  localparam int NCS_CH_W            = 8;   // one color channel
  localparam int NCS_ENTRY_W         = 3 * NCS_CH_W;
  localparam int NCS_COLOR15_W       = 15;
  localparam int NCS_IN_DATA_W       = 48;  // 47 payload bits, padded to bytes
  localparam int NCS_OUT_DATA_W      = 8;
  localparam int NCS_SQ_W            = 2 * NCS_CH_W;
  localparam int NCS_SUM_W           = 18;  // 3 * 255^2 fits
  localparam int NCS_ROOT_W          = NCS_SUM_W / 2;
  localparam int NCS_REM_W           = NCS_ROOT_W + 1;
  localparam int NCS_DIST_W          = 14;  // holds the start value
  localparam int NCS_DIST_START      = 10000;

  localparam logic [NCS_COLOR15_W-1:0] NCS_RED_MASK   = 15'h001F;
  localparam logic [NCS_COLOR15_W-1:0] NCS_GREEN_MASK = 15'h03E0;
  localparam logic [NCS_COLOR15_W-1:0] NCS_BLUE_MASK  = 15'h7C00;

  localparam logic NCS_MODE_LOAD  = 1'b0;
  localparam logic NCS_MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    NCS_IDLE,
    NCS_SCAN,
    NCS_DRAIN,
    NCS_DONE
  } ncs_state_t;

  // Travels alongside each scanned entry through the datapath.
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [NCS_IDX_W-1:0] idx;
  } ncs_tag_t;

  // 5-bit channel expanded as (c << 3) + 4.
  function automatic logic [NCS_CH_W-1:0] ncs_expand(input logic [4:0] c);
    ncs_expand = {c, 3'b100};
  endfunction

endpackage
`default_nettype wire

FILE: design/ncs_palette_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_palette_ram
// Palette storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ncs_palette_ram #(
  parameter int DEPTH = ncs_pkg::NCS_PALETTE_ENTRIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [ncs_pkg::NCS_ENTRY_W-1:0] wr_data,
  input  wire logic                           rd_en,
  input  wire logic [AW-1:0]                  rd_addr,
  output logic      [ncs_pkg::NCS_ENTRY_W-1:0] rd_data
);

  logic [ncs_pkg::NCS_ENTRY_W-1:0] mem_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/ncs_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_dist
// Squared RGB distance: abs differences, squares, sum. Three stages.
// ----------------------------------------------------------------------------
module ncs_dist (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [ncs_pkg::NCS_CH_W-1:0]    q_red,
  input  wire logic [ncs_pkg::NCS_CH_W-1:0]    q_green,
  input  wire logic [ncs_pkg::NCS_CH_W-1:0]    q_blue,
  input  wire logic [ncs_pkg::NCS_ENTRY_W-1:0] entry,
  input  ncs_pkg::ncs_tag_t                    tag_in,
  output logic      [ncs_pkg::NCS_SUM_W-1:0]   sum,
  output ncs_pkg::ncs_tag_t                    tag_out
);

  localparam int CW = ncs_pkg::NCS_CH_W;
  localparam int SW = ncs_pkg::NCS_SQ_W;
  localparam int UW = ncs_pkg::NCS_SUM_W;

  logic [CW-1:0] e_red, e_green, e_blue;
  logic [CW-1:0] d_red_r, d_green_r, d_blue_r;
  logic [SW-1:0] s_red_r, s_green_r, s_blue_r;
  logic [UW-1:0] sum_r;
  ncs_pkg::ncs_tag_t tag1_r, tag2_r, tag3_r;

  assign e_red   = entry[CW-1:0];
  assign e_green = entry[2*CW-1:CW];
  assign e_blue  = entry[3*CW-1:2*CW];

  function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk) begin
    d_red_r   <= absdiff(q_red, e_red);
    d_green_r <= absdiff(q_green, e_green);
    d_blue_r  <= absdiff(q_blue, e_blue);
    s_red_r   <= d_red_r * d_red_r;
    s_green_r <= d_green_r * d_green_r;
    s_blue_r  <= d_blue_r * d_blue_r;
    sum_r     <= UW'(s_red_r) + UW'(s_green_r) + UW'(s_blue_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  assign sum     = sum_r;
  assign tag_out = tag3_r;

endmodule
`default_nettype wire

FILE: design/ncs_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ncs_isqrt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [ncs_pkg::NCS_SUM_W-1:0]  value,
  input  ncs_pkg::ncs_tag_t                   tag_in,
  output logic      [ncs_pkg::NCS_ROOT_W-1:0] root,
  output ncs_pkg::ncs_tag_t                   tag_out
);

  localparam int RW = ncs_pkg::NCS_ROOT_W;
  localparam int MW = ncs_pkg::NCS_REM_W;
  localparam int UW = ncs_pkg::NCS_SUM_W;

  logic [RW-1:0]     root_r [0:RW-1];
  logic [MW-1:0]     rem_r  [0:RW-2];
  logic [UW-1:0]     v_r    [0:RW-2];
  ncs_pkg::ncs_tag_t tag_r  [0:RW-1];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int Pair = RW - 1 - s;
    logic [UW-1:0]     v_in;
    logic [RW-1:0]     root_in;
    logic [MW-1:0]     rem_in;
    ncs_pkg::ncs_tag_t tag_in_s;
    logic [MW+1:0]     rem_sh;
    logic [MW+1:0]     trial;
    logic [MW+1:0]     diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_in     = value;
      assign root_in  = '0;
      assign rem_in   = '0;
      assign tag_in_s = tag_in;
    end else begin : g_next
      assign v_in     = v_r[s-1];
      assign root_in  = root_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign tag_in_s = tag_r[s-1];
    end

    assign rem_sh = {rem_in, v_in[2*Pair+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      root_r[s] <= {root_in[RW-2:0], ge};
    end

    // remainder stays below 2*root+1, so it fits MW bits
    if (s < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[s] <= ge ? diff[MW-1:0] : rem_sh[MW-1:0];
        v_r[s]   <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s] <= '0;
      end else begin
        tag_r[s] <= tag_in_s;
      end
    end
  end

  assign root    = root_r[RW-1];
  assign tag_out = tag_r[RW-1];

endmodule
`default_nettype wire

FILE: design/nearest_palette_color_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette RAM with a sequential nearest-color scan.
// ----------------------------------------------------------------------------
// Each input transaction is either a load (in_tuser = 0), which writes one
// palette entry and gives no result, or a query (in_tuser = 1), which
// expands the 15-bit color to 8 bits per channel and scans entries
// 0 .. PALETTE_ENTRIES-1, one palette RAM read per cycle. Each entry passes
// through a 3-stage distance pipe and a 9-stage square-root pipe; the first
// entry with the strictly smallest floored distance wins. After a query is
// accepted, in_tready stays low until its result enters the output register.
// Loads with an index at or above PALETTE_ENTRIES are dropped. Every entry
// must be loaded before the first query; there is no clearing pass. A
// finished result sits in an output register, so loads are taken while it
// waits.
// ----------------------------------------------------------------------------
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = ncs_pkg::NCS_PALETTE_ENTRIES
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
  // [46:32] color15, [47] zero pad
  input  wire logic [ncs_pkg::NCS_IN_DATA_W-1:0]  in_tdata,
  // [0] mode: 0 load, 1 query
  input  wire logic                               in_tuser,
  // result channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [7:0] nearest_index
  output logic      [ncs_pkg::NCS_OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int IW = ncs_pkg::NCS_IDX_W;
  localparam int CW = ncs_pkg::NCS_CH_W;
  localparam int DW = ncs_pkg::NCS_DIST_W;
  localparam int RW = ncs_pkg::NCS_ROOT_W;
  localparam logic [AW-1:0] LastAddr = AW'(PALETTE_ENTRIES - 1);

  // unpacked input fields
  logic [IW-1:0]                    f_entry_index;
  logic [CW-1:0]                    f_red, f_green, f_blue;
  logic [ncs_pkg::NCS_COLOR15_W-1:0] f_color15;

  assign f_entry_index = in_tdata[7:0];
  assign f_red         = in_tdata[15:8];
  assign f_green       = in_tdata[23:16];
  assign f_blue        = in_tdata[31:24];
  assign f_color15     = in_tdata[46:32];

  logic in_fire, load_fire, query_fire, in_range;

  assign in_fire    = in_tvalid && in_tready;
  assign load_fire  = in_fire && (in_tuser == ncs_pkg::NCS_MODE_LOAD);
  assign query_fire = in_fire && (in_tuser == ncs_pkg::NCS_MODE_QUERY);
  assign in_range   = ({1'b0, f_entry_index} < (IW + 1)'(PALETTE_ENTRIES));

  // query color, expanded once at acceptance
  logic [CW-1:0] q_red_r, q_green_r, q_blue_r;
  logic [ncs_pkg::NCS_COLOR15_W-1:0] c_red, c_green, c_blue;

  assign c_red   = f_color15 & ncs_pkg::NCS_RED_MASK;
  assign c_green = (f_color15 & ncs_pkg::NCS_GREEN_MASK) >> 5;
  assign c_blue  = (f_color15 & ncs_pkg::NCS_BLUE_MASK) >> 10;

  always_ff @(posedge clk) begin
    if (query_fire) begin
      q_red_r   <= ncs_pkg::ncs_expand(c_red[4:0]);
      q_green_r <= ncs_pkg::ncs_expand(c_green[4:0]);
      q_blue_r  <= ncs_pkg::ncs_expand(c_blue[4:0]);
    end
  end

  // scan control
  ncs_pkg::ncs_state_t state_r, state_nxt;
  logic [AW-1:0]       scan_addr_r, scan_addr_nxt;
  logic                rd_en, res_load;
  ncs_pkg::ncs_tag_t   issue_tag, rd_tag_r, dist_tag, root_tag;
  logic [ncs_pkg::NCS_ENTRY_W-1:0] rd_data;
  logic [ncs_pkg::NCS_SUM_W-1:0]   dist_sum;
  logic [RW-1:0]                   root;
  logic                            out_tvalid_r;

  always_comb begin
    state_nxt     = state_r;
    scan_addr_nxt = scan_addr_r;
    in_tready     = 1'b0;
    rd_en         = 1'b0;
    res_load      = 1'b0;
    case (state_r)
      ncs_pkg::NCS_IDLE: begin
        in_tready = 1'b1;
        if (query_fire) begin
          state_nxt     = ncs_pkg::NCS_SCAN;
          scan_addr_nxt = '0;
        end
      end
      ncs_pkg::NCS_SCAN: begin
        rd_en         = 1'b1;
        scan_addr_nxt = scan_addr_r + AW'(1);
        if (scan_addr_r == LastAddr) begin
          state_nxt = ncs_pkg::NCS_DRAIN;
        end
      end
      ncs_pkg::NCS_DRAIN: begin
        // last entry leaves the compare stage
        if (root_tag.valid && root_tag.last) begin
          state_nxt = ncs_pkg::NCS_DONE;
        end
      end
      ncs_pkg::NCS_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          res_load  = 1'b1;
          state_nxt = ncs_pkg::NCS_IDLE;
        end
      end
      default: begin
        state_nxt = ncs_pkg::NCS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ncs_pkg::NCS_IDLE;
      scan_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
    end
  end

  assign issue_tag.valid = rd_en;
  assign issue_tag.last  = (scan_addr_r == LastAddr);
  assign issue_tag.idx   = IW'(scan_addr_r);

  // tag follows the RAM read latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= issue_tag;
    end
  end

  // loads are only taken in idle, so no read can overlap a write
  ncs_palette_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load_fire && in_range),
    .wr_addr (f_entry_index[AW-1:0]),
    .wr_data ({f_blue, f_green, f_red}),
    .rd_en   (rd_en),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  ncs_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_red   (q_red_r),
    .q_green (q_green_r),
    .q_blue  (q_blue_r),
    .entry   (rd_data),
    .tag_in  (rd_tag_r),
    .sum     (dist_sum),
    .tag_out (dist_tag)
  );

  ncs_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .value   (dist_sum),
    .tag_in  (dist_tag),
    .root    (root),
    .tag_out (root_tag)
  );

  // running best; start value exceeds any floored distance
  logic [DW-1:0] best_d_r;
  logic [IW-1:0] best_idx_r;

  always_ff @(posedge clk) begin
    if (query_fire) begin
      best_d_r   <= DW'(ncs_pkg::NCS_DIST_START);
      best_idx_r <= '0;
    end else if (root_tag.valid && (DW'(root) < best_d_r)) begin
      best_d_r   <= DW'(root);
      best_idx_r <= root_tag.idx;
    end
  end

  // output register
  logic [ncs_pkg::NCS_OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= best_idx_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: design/ncs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_checker
// Port-level checks for the nearest palette color search block.
// ----------------------------------------------------------------------------
module ncs_checker #(
  parameter int PALETTE_ENTRIES = ncs_pkg::NCS_PALETTE_ENTRIES
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               in_tuser,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [ncs_pkg::NCS_OUT_DATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // index always within the palette
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata} < 9'(PALETTE_ENTRIES)))
    else $error("result index beyond palette");

  // a query blocks further input while it scans
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken during a scan");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("load produced a result");

  // a result never rises right after a query is accepted
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready && in_tuser))
    else $error("result too early after query");

endmodule

bind nearest_palette_color_search ncs_checker #(
  .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_ncs_checker (.*);
`default_nettype wire
